// ----- src/lpp_pkg.sv -----
// ----------------------------------------------------------------------------
// lpp_pkg
// shared types and constants of the least-prime-in-progression core
// ----------------------------------------------------------------------------
package lpp_pkg;

  localparam int LIMIT_W = 20;  // sieve limit and largest prime
  localparam int VALUE_W = 21;  // signed result value

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = '1;
  localparam logic [VALUE_W-1:0] VALUE_NONE  = '1;  // -1
  localparam int                 MIN_PRIME   = 2;

  localparam logic OP_BUILD = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,       // fill bitmap: 0,1 composite, rest candidate
    ST_SV_CHK,     // sieve: i*i within limit, read flag of i
    ST_SV_TEST,    // sieve: i still prime?
    ST_MARK,       // sieve: strike multiples of i
    ST_SCAN_RD,    // scan down for the largest prime
    ST_SCAN_TEST,
    ST_Q_NEXT,     // next residue of a query
    ST_G_START,    // one euclid step
    ST_G_WAIT,     // wait for remainder unit
    ST_W_CHK,      // walk: bound check, read term
    ST_W_TEST,     // walk: term prime?
    ST_DONE
  } seq_state_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      more;
    logic                      not_built;
  } res_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic wr_data;
  } bm_ctl_t;

endpackage

// ----- src/least_prime_in_progression_core.sv -----
// ----------------------------------------------------------------------------
// least_prime_in_progression_core
// least primes in arithmetic progressions over a sieved prime bitmap
//
// A beat with tuser = build runs a sieve of eratosthenes over 0..prime_limit
// (capped at SIEVE_SIZE-1) into a one-bit-wide on-chip bitmap and returns the
// largest prime found, or -1 if there is none. A beat with tuser = query
// carries a modulus m; for every residue a in 1..m-1 with gcd(a, m) == 1 the
// core walks a, a+m, a+2m, ... to its first prime and returns the largest of
// those least primes (-1 if none), raising the walk_overflow flag when a walk
// runs past the largest sieved prime. A query before any build returns -1
// with not_built set. One item is worked at a time. A build fills the
// bitmap, strikes the multiples of each sieving prime up to sqrt(lim) and
// then scans down from lim to the largest prime. A query runs, for each
// residue, euclid steps on the bit-serial remainder unit and then reads the
// progression terms from the single-port bitmap memory until a prime or the
// bound check ends the walk. The result sits in an output register, so the
// next item is taken while the previous result waits on m_tready.
// prime_limit is written over its own channel, which is always ready; write
// it only while the core is idle. There is no clearing pass after reset: a
// query only reads entries that the last build wrote.
// ----------------------------------------------------------------------------
module least_prime_in_progression_core
  import lpp_pkg::*;
#(
  parameter int SIEVE_SIZE    = 1048576,
  parameter int MODULUS_WIDTH = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // configuration: prime_limit
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [LIMIT_W-1:0]                     cfg_data,
  // input stream
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [((MODULUS_WIDTH+7)/8)*8-1:0]     s_tdata,   // modulus
  input  logic [0:0]                             s_tuser,   // opcode
  // result stream
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [((VALUE_W+7)/8)*8-1:0]           m_tdata,   // prime_value
  output logic [1:0]                             m_tuser    // walk_overflow, not_built
);

  localparam int ADDR_W     = (SIEVE_SIZE > 1) ? $clog2(SIEVE_SIZE) : 1;
  localparam int NUM_W      = ((MODULUS_WIDTH > LIMIT_W) ? MODULUS_WIDTH : LIMIT_W) + 2;
  localparam int OUT_DATA_W = ((VALUE_W + 7) / 8) * 8;

  logic [LIMIT_W-1:0]       prime_limit;
  logic                     res_valid;
  logic                     res_ready;
  res_t                     res;
  bm_ctl_t                  bm_ctl;
  logic [ADDR_W-1:0]        bm_addr;
  logic                     bm_rd_data;
  logic                     rem_start;
  logic                     rem_done;
  logic [MODULUS_WIDTH-1:0] rem_dividend;
  logic [MODULUS_WIDTH-1:0] rem_divisor;
  logic [MODULUS_WIDTH-1:0] rem_result;

  // limit register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      prime_limit <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      prime_limit <= cfg_data;
    end
  end

  // sequencer holds build/query control and the small state
  lpp_seq #(
    .SIEVE_SIZE    (SIEVE_SIZE),
    .MODULUS_WIDTH (MODULUS_WIDTH),
    .ADDR_W        (ADDR_W),
    .NUM_W         (NUM_W)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .prime_limit  (prime_limit),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .in_opcode    (s_tuser[0]),
    .in_modulus   (s_tdata[MODULUS_WIDTH-1:0]),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res),
    .bm_ctl       (bm_ctl),
    .bm_addr      (bm_addr),
    .bm_rd_data   (bm_rd_data),
    .rem_start    (rem_start),
    .rem_dividend (rem_dividend),
    .rem_divisor  (rem_divisor),
    .rem_done     (rem_done),
    .rem_result   (rem_result)
  );

  // prime flag per number
  lpp_bitmap #(
    .DEPTH  (SIEVE_SIZE),
    .ADDR_W (ADDR_W)
  ) u_bitmap (
    .clk     (clk),
    .ctl     (bm_ctl),
    .addr    (bm_addr),
    .rd_data (bm_rd_data)
  );

  // euclid remainder, one bit per cycle
  lpp_rem #(
    .W (MODULUS_WIDTH)
  ) u_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (rem_start),
    .dividend  (rem_dividend),
    .divisor   (rem_divisor),
    .done      (rem_done),
    .remainder (rem_result)
  );

  // output register: result waits here while the next item is taken
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= {{(OUT_DATA_W - VALUE_W){1'b0}}, res.value};
      m_tuser <= {res.not_built, res.more};
    end
  end

endmodule

// ----- src/lpp_bitmap.sv -----
// ----------------------------------------------------------------------------
// lpp_bitmap
// one-bit-wide prime flag memory, one port, registered read
// ----------------------------------------------------------------------------
module lpp_bitmap
  import lpp_pkg::*;
#(
  parameter int DEPTH  = 1048576,
  parameter int ADDR_W = 20
) (
  input  logic              clk,
  input  bm_ctl_t           ctl,
  input  logic [ADDR_W-1:0] addr,
  output logic              rd_data
);

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[addr] <= ctl.wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[addr];
    end
  end

endmodule

// ----- src/lpp_rem.sv -----
// ----------------------------------------------------------------------------
// lpp_rem
// bit-serial restoring remainder unit, one dividend bit per cycle
// ----------------------------------------------------------------------------
module lpp_rem
  import lpp_pkg::*;
#(
  parameter int W = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] remainder
);

  localparam int CNT_W = $clog2(W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [W-1:0]     shreg;
  logic [W-1:0]     acc;
  logic [W-1:0]     dvs;
  logic [W:0]       trial;

  assign trial     = {acc, shreg[W-1]};
  assign remainder = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == CNT_W'(1))) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt   <= CNT_W'(W);
      shreg <= dividend;
      acc   <= '0;
      dvs   <= divisor;
    end else if (busy) begin
      cnt   <= cnt - CNT_W'(1);
      shreg <= shreg << 1;
      if (trial >= {1'b0, dvs}) begin
        acc <= W'(trial - {1'b0, dvs});
      end else begin
        acc <= W'(trial);
      end
    end
  end

endmodule

// ----- src/lpp_seq.sv -----
// ----------------------------------------------------------------------------
// lpp_seq
// sequencer: sieve build, largest-prime scan, euclid and progression walks
// ----------------------------------------------------------------------------
module lpp_seq
  import lpp_pkg::*;
#(
  parameter int SIEVE_SIZE    = 1048576,
  parameter int MODULUS_WIDTH = 16,
  parameter int ADDR_W        = 20,
  parameter int NUM_W         = 22
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [LIMIT_W-1:0]       prime_limit,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_opcode,
  input  logic [MODULUS_WIDTH-1:0] in_modulus,
  output logic                     res_valid,
  input  logic                     res_ready,
  output res_t                     res,
  output bm_ctl_t                  bm_ctl,
  output logic [ADDR_W-1:0]        bm_addr,
  input  logic                     bm_rd_data,
  output logic                     rem_start,
  output logic [MODULUS_WIDTH-1:0] rem_dividend,
  output logic [MODULUS_WIDTH-1:0] rem_divisor,
  input  logic                     rem_done,
  input  logic [MODULUS_WIDTH-1:0] rem_result
);

  localparam longint TOP_IDX = longint'(SIEVE_SIZE) - 1;

  seq_state_t state, state_next;

  logic                     op;
  logic [NUM_W-1:0]         lim;
  logic [NUM_W-1:0]         lim_cap;
  logic [NUM_W-1:0]         i;
  logic [NUM_W-1:0]         sq;
  logic [NUM_W-1:0]         t;
  logic [MODULUS_WIDTH-1:0] m;
  logic [MODULUS_WIDTH-1:0] a;
  logic [MODULUS_WIDTH-1:0] x;
  logic [MODULUS_WIDTH-1:0] y;
  logic [LIMIT_W-1:0]       best;
  logic                     found;
  logic                     over;
  logic [LIMIT_W-1:0]       largest;
  logic                     built;

  logic [NUM_W-1:0] largest_ext;
  logic [NUM_W-1:0] two;

  assign largest_ext = NUM_W'(largest);
  assign two         = NUM_W'(MIN_PRIME);
  assign lim_cap     = (longint'(prime_limit) > TOP_IDX) ? NUM_W'(TOP_IDX)
                                                         : NUM_W'(prime_limit);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_opcode == OP_BUILD) begin
            state_next = ST_INIT;
          end else if (!built) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_Q_NEXT;
          end
        end
      end
      ST_INIT:      if (t == lim) state_next = ST_SV_CHK;
      ST_SV_CHK:    state_next = (sq > lim) ? ST_SCAN_RD : ST_SV_TEST;
      ST_SV_TEST:   state_next = bm_rd_data ? ST_MARK : ST_SV_CHK;
      ST_MARK:      if (t > lim) state_next = ST_SV_CHK;
      ST_SCAN_RD:   state_next = (t < two) ? ST_DONE : ST_SCAN_TEST;
      ST_SCAN_TEST: state_next = bm_rd_data ? ST_DONE : ST_SCAN_RD;
      ST_Q_NEXT:    state_next = (a >= m) ? ST_DONE : ST_G_START;
      ST_G_START: begin
        if (y != '0) begin
          state_next = ST_G_WAIT;
        end else begin
          state_next = (x == MODULUS_WIDTH'(1)) ? ST_W_CHK : ST_Q_NEXT;
        end
      end
      ST_G_WAIT:    if (rem_done) state_next = ST_G_START;
      ST_W_CHK:     state_next = (t > largest_ext) ? ST_Q_NEXT : ST_W_TEST;
      ST_W_TEST:    state_next = bm_rd_data ? ST_Q_NEXT : ST_W_CHK;
      ST_DONE:      if (res_ready) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    bm_ctl         = '0;
    bm_addr        = ADDR_W'(t);
    rem_start      = 1'b0;
    in_ready       = 1'b0;
    res_valid      = 1'b0;
    unique case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_INIT: begin
        bm_ctl.wr_en   = 1'b1;
        bm_ctl.wr_data = (t >= two);
      end
      ST_SV_CHK: begin
        bm_addr      = ADDR_W'(i);
        bm_ctl.rd_en = (sq <= lim);
      end
      ST_MARK:    bm_ctl.wr_en = (t <= lim);
      ST_SCAN_RD: bm_ctl.rd_en = (t >= two);
      ST_G_START: rem_start    = (y != '0);
      ST_W_CHK:   bm_ctl.rd_en = (t <= largest_ext);
      ST_DONE:    res_valid    = 1'b1;
      default: begin
      end
    endcase
  end

  assign rem_dividend = x;
  assign rem_divisor  = y;

  always_comb begin
    res = '0;
    if (op == OP_BUILD) begin
      res.value = (largest == '0) ? VALUE_NONE : VALUE_W'(largest);
    end else if (!built) begin
      res.value     = VALUE_NONE;
      res.not_built = 1'b1;
    end else begin
      res.value = found ? VALUE_W'(best) : VALUE_NONE;
      res.more  = over;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      built   <= 1'b0;
      largest <= '0;
    end else begin
      state <= state_next;
      if (state == ST_SCAN_RD && t < two) begin
        largest <= '0;
        built   <= 1'b1;
      end else if (state == ST_SCAN_TEST && bm_rd_data) begin
        largest <= LIMIT_W'(t);
        built   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          op    <= in_opcode;
          m     <= in_modulus;
          a     <= MODULUS_WIDTH'(1);
          found <= 1'b0;
          over  <= 1'b0;
          t     <= '0;
          lim   <= lim_cap;
          i     <= two;
          sq    <= NUM_W'(MIN_PRIME * MIN_PRIME);
        end
      end
      ST_INIT: t <= t + NUM_W'(1);
      ST_SV_CHK: if (sq > lim) t <= lim;
      ST_SV_TEST: begin
        if (bm_rd_data) begin
          t <= sq;
        end else begin
          i  <= i + NUM_W'(1);
          sq <= sq + (i << 1) + NUM_W'(1);
        end
      end
      ST_MARK: begin
        if (t > lim) begin
          i  <= i + NUM_W'(1);
          sq <= sq + (i << 1) + NUM_W'(1);
        end else begin
          t <= t + i;
        end
      end
      ST_SCAN_TEST: if (!bm_rd_data) t <= t - NUM_W'(1);
      ST_Q_NEXT: begin
        x <= a;
        y <= m;
      end
      ST_G_START: begin
        if (y == '0) begin
          if (x == MODULUS_WIDTH'(1)) begin
            t <= NUM_W'(a);
          end else begin
            a <= a + MODULUS_WIDTH'(1);
          end
        end
      end
      ST_G_WAIT: begin
        if (rem_done) begin
          x <= y;
          y <= rem_result;
        end
      end
      ST_W_CHK: begin
        if (t > largest_ext) begin
          over <= 1'b1;
          a    <= a + MODULUS_WIDTH'(1);
        end
      end
      ST_W_TEST: begin
        if (bm_rd_data) begin
          if (!found || LIMIT_W'(t) > best) begin
            best <= LIMIT_W'(t);
          end
          found <= 1'b1;
          a     <= a + MODULUS_WIDTH'(1);
        end else begin
          t <= t + NUM_W'(m);
        end
      end
      default: begin
      end
    endcase
  end

  // single-port memory: never a read and a write in one cycle
  a_port_excl: assert property (@(posedge clk) disable iff (rst)
    !(bm_ctl.rd_en && bm_ctl.wr_en))
    else $error("bitmap read and write in the same cycle");

  // a remainder never comes back for a zero divisor
  a_rem_divisor: assert property (@(posedge clk) disable iff (rst)
    (state == ST_G_WAIT && rem_done) |-> (y != '0))
    else $error("remainder taken with zero divisor");

  // a prime found on a walk lies within the sieved range
  a_walk_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_W_TEST && bm_rd_data) |-> (t <= largest_ext))
    else $error("walk hit beyond largest prime");

  // once built, the bitmap stays valid
  a_built_sticky: assert property (@(posedge clk) disable iff (rst)
    built |=> built)
    else $error("bitmap valid flag dropped");

endmodule

// ----- test/least_prime_in_progression_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// least_prime_in_progression_core_tb
// self-checking bench for the least-prime-in-progression core
//
// Sends build and query beats and predicts every result with its own sieve
// and euclid walk. Each result beat is compared field by field. Sender and
// receiver idle at random, and one long receiver hold-off fills the core
// until it stalls its input. A watchdog ends the run if beats stop moving.
// ----------------------------------------------------------------------------
module least_prime_in_progression_core_tb
  import lpp_pkg::*;
();

  localparam int SIEVE_DEPTH  = 1048576;
  localparam int MOD_W        = 16;
  localparam int DATA_W       = ((MOD_W + 7) / 8) * 8;
  localparam int RES_DATA_W   = ((VALUE_W + 7) / 8) * 8;
  // the limit must cover a full-size build, during which no beat moves
  localparam int STALL_LIMIT  = 20_000_000;
  localparam int MAX_REPORTS  = 10;
  localparam int DRAIN_CYCLES = 64;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [LIMIT_W-1:0]    cfg_data  = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [DATA_W-1:0]     s_tdata   = '0;   // modulus
  logic [0:0]            s_tuser   = OP_BUILD;  // opcode
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [RES_DATA_W-1:0] m_tdata;          // prime_value
  logic [1:0]            m_tuser;          // walk_overflow, not_built

  // bench copy of the core state
  bit                 prime_map [SIEVE_DEPTH];
  logic [LIMIT_W-1:0] sieve_limit = LIMIT_RESET;
  logic [LIMIT_W-1:0] top_prime   = '0;
  bit                 map_built   = 1'b0;

  res_t pending_results [$];
  res_t head_result;
  int   error_count   = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   hold_cycles   = 0;
  int   stall_count   = 0;

  least_prime_in_progression_core DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------
  function automatic int unsigned euclid_gcd(int unsigned x, int unsigned y);
    int unsigned r;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    return x;
  endfunction

  // sieve 0..limit, remember the largest prime
  function automatic res_t sieve_build();
    int unsigned lim;
    res_t        r;
    lim = sieve_limit;
    if (lim > SIEVE_DEPTH - 1) lim = SIEVE_DEPTH - 1;
    for (int unsigned i = 0; i <= lim; i++) prime_map[i] = (i >= MIN_PRIME);
    for (int unsigned i = MIN_PRIME; i * i <= lim; i++) begin
      if (prime_map[i]) begin
        for (int unsigned j = i * i; j <= lim; j += i) prime_map[j] = 1'b0;
      end
    end
    top_prime = '0;
    for (int unsigned i = lim; i >= MIN_PRIME; i--) begin
      if (prime_map[i]) begin
        top_prime = LIMIT_W'(i);
        break;
      end
    end
    map_built   = 1'b1;
    r           = '0;
    r.value     = (top_prime == '0) ? VALUE_NONE : {1'b0, top_prime};
    return r;
  endfunction

  // largest of the least primes over all residues coprime to m
  function automatic res_t progression_query(int unsigned m);
    res_t        r;
    int unsigned best;
    int unsigned t;
    bit          found;
    r     = '0;
    best  = 0;
    found = 1'b0;
    if (!map_built) begin
      r.value     = VALUE_NONE;
      r.not_built = 1'b1;
      return r;
    end
    for (int unsigned a = 1; a < m; a++) begin
      if (euclid_gcd(a, m) != 1) continue;
      t = a;
      while (1) begin
        // walk ran past the sieved range
        if (t > top_prime) begin
          r.more = 1'b1;
          break;
        end
        if (prime_map[t]) begin
          if (!found || t > best) best = t;
          found = 1'b1;
          break;
        end
        t += m;
      end
    end
    r.value = found ? VALUE_W'(best) : VALUE_NONE;
    return r;
  endfunction

  function automatic res_t predict_result(logic op, logic [MOD_W-1:0] modulus);
    if (op == OP_BUILD) return sieve_build();
    return progression_query(modulus);
  endfunction

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic op, input logic [MOD_W-1:0] modulus);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= DATA_W'(modulus);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.insert(pending_results.size(), predict_result(op, modulus));
  endtask

  // stop offering beats and wait for every outstanding result
  task automatic wait_for_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // limit is only touched with the core idle
  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    wait_for_results();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sieve_limit = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [LIMIT_W-1:0] pick_limit();
    case ($urandom_range(0, 3))
      0:       return LIMIT_W'($urandom_range(2, 40));
      1:       return LIMIT_W'($urandom_range(41, 400));
      default: return LIMIT_W'($urandom_range(401, 3000));
    endcase
  endfunction

  // mostly small moduli: query time grows with the modulus
  function automatic logic [MOD_W-1:0] pick_modulus();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 16) return MOD_W'($urandom_range(0, 48));
    if (sel < 19) return MOD_W'($urandom_range(49, 160));
    return MOD_W'($urandom_range(161, 255));
  endfunction

  // ---------------------------------------------------------------------------
  // receiver side: random stalls, or a counted hold-off
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_tready    <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // result checker
  // ---------------------------------------------------------------------------
  function automatic void flag_mismatch(string field, int exp_val, int act_val);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("mismatch on %s: expected %0d, got %0d", field, exp_val, act_val);
  endfunction

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("result beat with nothing expected: value %0d",
                   $signed(m_tdata[VALUE_W-1:0]));
      end else begin
        head_result = pending_results.pop_front();
        if (m_tdata[VALUE_W-1:0] !== head_result.value)
          flag_mismatch("prime_value", head_result.value,
                        $signed(m_tdata[VALUE_W-1:0]));
        // padding above the value must stay zero
        if (m_tdata[RES_DATA_W-1:VALUE_W] !== '0)
          flag_mismatch("tdata padding", 0, m_tdata[RES_DATA_W-1:VALUE_W]);
        if (m_tuser[0] !== head_result.more)
          flag_mismatch("walk_overflow", head_result.more, m_tuser[0]);
        if (m_tuser[1] !== head_result.not_built)
          flag_mismatch("not_built", head_result.not_built, m_tuser[1]);
      end
    end
  end

  // watchdog: cycles in a row with no beat on any channel
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_count = 0;
    end else begin
      stall_count++;
      if (stall_count >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  task automatic test_query_before_build();
    send_item(OP_QUERY, 16'hFFFF);
    send_item(OP_QUERY, 16'h0000);
  endtask

  // limits of zero and one leave no prime, so every walk overflows
  task automatic test_limit_below_two();
    write_limit(LIMIT_W'(0));
    send_item(OP_BUILD, 16'hFFFF);
    send_item(OP_QUERY, 16'd2);
    send_item(OP_QUERY, 16'd1);
    write_limit(LIMIT_W'(1));
    send_item(OP_BUILD, 16'h5A5A);
    send_item(OP_QUERY, 16'd6);
  endtask

  task automatic test_smallest_prime();
    write_limit(LIMIT_W'(MIN_PRIME));
    send_item(OP_BUILD, 16'hA5A5);
    send_item(OP_QUERY, 16'd3);
    send_item(OP_QUERY, 16'd2);
  endtask

  task automatic test_small_sieves();
    write_limit(LIMIT_W'(100));
    send_item(OP_BUILD, 16'h0000);
    send_item(OP_QUERY, 16'd0);
    send_item(OP_QUERY, 16'd10);
    send_item(OP_QUERY, 16'd30);
    send_item(OP_QUERY, 16'd97);
    write_limit(LIMIT_W'(1000));
    send_item(OP_BUILD, 16'h1234);
    send_item(OP_QUERY, 16'd12);
    send_item(OP_QUERY, 16'd60);
  endtask

  // one build over the whole bitmap, then a short one that leaves stale entries
  task automatic test_full_sieve();
    write_limit(LIMIT_RESET);
    send_item(OP_BUILD, 16'h8000 | MOD_W'($urandom()));
    send_item(OP_QUERY, 16'd64);
    send_item(OP_QUERY, 16'd30);
    send_item(OP_QUERY, 16'd2);
    write_limit(LIMIT_W'(50));
    send_item(OP_BUILD, MOD_W'($urandom()));
    send_item(OP_QUERY, 16'd40);
  endtask

  // receiver holds off while cheap queries pile up behind the result register
  task automatic test_backpressure();
    wait_for_results();
    hold_cycles = 800;
    for (int n = 0; n < 8; n++) send_item(OP_QUERY, MOD_W'($urandom_range(0, 5)));
    wait_for_results();
  endtask

  task automatic test_random_traffic(input int tx_idle, input int rx_idle,
                                     input int count);
    send_idle_pct = tx_idle;
    recv_idle_pct = rx_idle;
    for (int n = 0; n < count; n++) begin
      if (n == 0 || n == count / 2) begin
        write_limit(pick_limit());
        send_item(OP_BUILD, MOD_W'($urandom()));
      end else if ($urandom_range(0, 4) == 0) begin
        send_item(OP_BUILD, MOD_W'($urandom()));
      end else begin
        send_item(OP_QUERY, pick_modulus());
      end
    end
  endtask

  initial begin
    send_idle_pct = 6;
    recv_idle_pct = 52;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_query_before_build();
    test_limit_below_two();
    test_smallest_prime();
    test_small_sieves();
    test_full_sieve();
    test_random_traffic(6, 52, 26);
    test_backpressure();
    test_random_traffic(52, 6, 26);
    test_random_traffic(0, 0, 26);

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
